// ===== src/mbps_pkg.sv =====
// shared types and constants for the masked byte pattern scanner
`default_nettype none

package mbps_pkg;

   localparam int MAX_PATTERN  = 16;
   localparam int OFFSET_WIDTH = 32;
   localparam int MATCH_OFF_W  = 32;
   localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
   localparam int WIN_IDX_W    = $clog2(MAX_PATTERN);
   localparam int PATTERN_W    = 64;
   localparam int CARE_W       = 16;
   localparam int STRIDE_W     = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int QUEUE_DEPTH  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PAT_LEN        = 3'd3,
      CSR_SCAN_STRIDE    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern_low;
      logic [PATTERN_W-1:0] pattern_high;
      logic [CARE_W-1:0]    care_mask;
      logic [LEN_W-1:0]     pat_len;
      logic [STRIDE_W-1:0]  scan_stride;
   } cfg_type;

   typedef struct packed {
      logic                   found;
      logic [MATCH_OFF_W-1:0] match_offset;
   } result_type;

endpackage

`default_nettype wire

// ===== src/mbps_if.sv =====
// channel interfaces: byte input, result output and register write
`default_nettype none

interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [mbps_pkg::MATCH_OFF_W-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink (input valid, input found, input match_offset, output ready);
endinterface

interface mbps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mbps_pkg::CSR_INDEX_W-1:0] index;
   logic [mbps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/mbps_csr.sv =====
// configuration register file
`default_nettype none

module mbps_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   mbps_csr_if.sink         csr_chan,
   output mbps_pkg::cfg_type cfg
);
   import mbps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PATTERN_LOW:  cfg_in.pattern_low  = csr_chan.data;
            CSR_PATTERN_HIGH: cfg_in.pattern_high = csr_chan.data;
            CSR_CARE_MASK:    cfg_in.care_mask    = csr_chan.data[CARE_W-1:0];
            CSR_PAT_LEN:      cfg_in.pat_len      = csr_chan.data[LEN_W-1:0];
            CSR_SCAN_STRIDE:  cfg_in.scan_stride  = csr_chan.data[STRIDE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low  <= '0;
         cfg_ff.pattern_high <= '0;
         cfg_ff.care_mask    <= '0;
         cfg_ff.pat_len      <= LEN_W'(1);
         cfg_ff.scan_stride  <= STRIDE_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mbps_front.sv =====
// front end: byte window, candidate offset tracking and masked compare
`default_nettype none

module mbps_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire mbps_pkg::cfg_type cfg,
   input  wire logic            accept,
   input  wire logic [7:0]      data_byte,
   input  wire logic            last_byte,
   output logic                 push,
   output mbps_pkg::result_type push_data
);
   import mbps_pkg::*;

   logic [7:0]              window_ff [MAX_PATTERN];
   logic [7:0]              window_in [MAX_PATTERN];
   logic [OFFSET_WIDTH-1:0] count_ff, count_in;
   logic [STRIDE_W-1:0]     phase_ff, phase_in;
   logic                    done_ff, done_in;

   logic [LEN_W-1:0]        len_eff;
   logic [WIN_IDX_W-1:0]    len_m1;
   logic [STRIDE_W-1:0]     stride_eff;
   logic [2*PATTERN_W-1:0]  pat_bytes;
   logic [MAX_PATTERN-1:0]  byte_ok;
   logic [WIN_IDX_W-1:0]    win_idx [MAX_PATTERN];
   logic                    candidate;
   logic                    hit;
   logic [STRIDE_W:0]       phase_inc;
   logic [OFFSET_WIDTH-1:0] start_off;

   // clamp the length to 1..MAX_PATTERN and the stride to at least 1
   always_comb begin
      if (cfg.pat_len == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.pat_len > LEN_W'(MAX_PATTERN)) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = cfg.pat_len;
      end
      len_m1     = WIN_IDX_W'(len_eff - LEN_W'(1));
      stride_eff = (cfg.scan_stride == '0) ? STRIDE_W'(1) : cfg.scan_stride;
      pat_bytes  = {cfg.pattern_high, cfg.pattern_low};
   end

   // new window, newest byte at entry 0
   always_comb begin
      window_in[0] = data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // pattern byte j lines up with window entry len-1-j
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         win_idx[j] = len_m1 - WIN_IDX_W'(j);
         byte_ok[j] = (LEN_W'(j) >= len_eff) || !cfg.care_mask[j]
                      || (window_in[win_idx[j]] == pat_bytes[8*j +: 8]);
      end
   end

   always_comb begin
      candidate = count_ff >= OFFSET_WIDTH'(len_m1);
      hit       = !done_ff && candidate && (phase_ff == '0) && (&byte_ok);
      phase_inc = {1'b0, phase_ff} + (STRIDE_W+1)'(1);
      start_off = count_ff - OFFSET_WIDTH'(len_m1);

      count_in  = count_ff;
      phase_in  = phase_ff;
      done_in   = done_ff;
      push      = 1'b0;
      push_data.found        = 1'b0;
      push_data.match_offset = '0;

      if (accept) begin
         if (!done_ff) begin
            if (hit) begin
               push                   = 1'b1;
               push_data.found        = 1'b1;
               push_data.match_offset = MATCH_OFF_W'(start_off);
               done_in                = 1'b1;
            end
            if (candidate) begin
               if (phase_inc >= {1'b0, stride_eff}) begin
                  phase_in = '0;
               end else begin
                  phase_in = phase_inc[STRIDE_W-1:0];
               end
            end
            if (count_ff != '1) begin
               count_in = count_ff + OFFSET_WIDTH'(1);
            end
         end
         if (last_byte) begin
            // region ended with no match reported
            if (!hit && !done_ff) begin
               push = 1'b1;
            end
            count_in = '0;
            phase_in = '0;
            done_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !done_ff) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mbps_fifo.sv =====
// short result queue between the front end and the output channel
`default_nettype none

module mbps_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mbps_pkg::result_type push_data,
   output logic                      full,
   input  wire logic                 pop,
   output mbps_pkg::result_type      pop_data,
   output logic                      empty
);
   import mbps_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/masked_byte_pattern_scanner_top.sv =====
// top level of the masked byte pattern scanner
`default_nettype none

// scans a memory region arriving one byte per transaction on req_chan, the
// region's final byte flagged by last_byte, for a pattern of up to 16 bytes
// held in pattern_low/pattern_high; bytes whose care_mask bit is clear match
// anything, and only start offsets that are multiples of scan_stride are tried.
// per region exactly one transaction leaves on rsp_chan: found set with the
// start offset of the first match (bytes after it up to the region's end are
// swallowed), or found clear when the region ends without one. the block then
// rearms. a byte is taken every cycle: the window shift, the sixteen masked
// byte compares and the offset bookkeeping all happen in the cycle the byte
// is accepted, and the result is written into the queue at that edge. results
// sit in a four-entry queue, so req_chan only stalls when four results are
// waiting for rsp_chan to take them. registers are written through csr_chan,
// which is always ready; writes are meant for when the block is idle
module masked_byte_pattern_scanner_top (
   input  wire logic  clock,
   input  wire logic  reset,
   mbps_req_if.sink   req_chan,
   mbps_rsp_if.source rsp_chan,
   mbps_csr_if.sink   csr_chan
);
   import mbps_pkg::*;

   cfg_type    cfg;
   logic       accept;
   logic       push;
   result_type push_data;
   result_type pop_data;
   logic       queue_full;
   logic       queue_empty;

   // register file
   mbps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // each byte yields at most one result, so a free queue slot is all we need
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // front end: window, candidate tracking and compare
   mbps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .push      (push),
      .push_data (push_data)
   );

   // result queue decouples the scan from the consumer
   mbps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (rsp_chan.ready),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // back end: head of the queue drives the result channel
   assign rsp_chan.valid        = !queue_empty;
   assign rsp_chan.found        = pop_data.found;
   assign rsp_chan.match_offset = pop_data.match_offset;

endmodule

`default_nettype wire

// ===== bench/tb_masked_byte_pattern_scanner_top.sv =====
// self-checking testbench for the masked byte pattern scanner top level
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner_top;
   import mbps_pkg::*;

   localparam time HALF_PERIOD  = 6ns;
   localparam int  RESET_CYCLES = 2;
   localparam int  IDLE_SLACK   = 4;
   localparam int  RANDOM_ITEMS = 1350;
   localparam int  REGION_MAX   = 80;
   localparam time RUN_LIMIT    = 6_000_000ns;

   // kinds of row in the directed table
   typedef enum logic [1:0] {
      ROW_WRITE,       // register write, issued once the block has gone quiet
      ROW_BYTE,        // byte checked against the predictor
      ROW_BYTE_TYPED   // byte whose result is written into the table
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      csr_index_type          reg_index;
      logic [CSR_DATA_W-1:0]  value;
      logic [7:0]             data_byte;
      logic                   last_byte;
      logic                   found;
      logic [MATCH_OFF_W-1:0] match_offset;
   } scan_row_type;

   localparam int NUM_ROWS = 37;

   // directed walk: reset defaults, short regions, a match on the final byte,
   // stride filtering, register masking, a stride change part way through a
   // region and the zero-stride case
   localparam scan_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // after reset: length 1, no care bits, so the first byte matches
      '{ROW_BYTE_TYPED, CSR_PATTERN_LOW, 64'h0, 8'h00, 1'b0, 1'b1, 32'd0},
      '{ROW_BYTE,       CSR_PATTERN_LOW, 64'h0, 8'hFF, 1'b1, 1'b0, 32'd0},
      '{ROW_BYTE_TYPED, CSR_PATTERN_LOW, 64'h0, 8'hA5, 1'b1, 1'b1, 32'd0},
      // three byte pattern aa bb cc, care bits beyond the length set
      '{ROW_WRITE, CSR_PATTERN_LOW,    64'h0000_0000_00CC_BBAA, 8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_CARE_MASK,      64'h0000_0000_0000_FFFF, 8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PAT_LEN,        64'd3,                   8'h00, 1'b0, 1'b0, 32'd0},
      // regions shorter than the pattern
      '{ROW_BYTE_TYPED, CSR_PATTERN_LOW, 64'h0, 8'hAA, 1'b1, 1'b0, 32'd0},
      '{ROW_BYTE,       CSR_PATTERN_LOW, 64'h0, 8'hAA, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE_TYPED, CSR_PATTERN_LOW, 64'h0, 8'hBB, 1'b1, 1'b0, 32'd0},
      // match completing on the final byte
      '{ROW_BYTE,       CSR_PATTERN_LOW, 64'h0, 8'h11, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,       CSR_PATTERN_LOW, 64'h0, 8'hAA, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,       CSR_PATTERN_LOW, 64'h0, 8'hBB, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE_TYPED, CSR_PATTERN_LOW, 64'h0, 8'hCC, 1'b1, 1'b1, 32'd1},
      // stride 2 rules out the odd start offset
      '{ROW_WRITE, CSR_SCAN_STRIDE, 64'd2, 8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW, 64'h0, 8'h11, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW, 64'h0, 8'hAA, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW, 64'h0, 8'hBB, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW, 64'h0, 8'hCC, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW, 64'h0, 8'h22, 1'b1, 1'b0, 32'd0},
      // length written as zero with junk above the field, acts as one
      '{ROW_WRITE, CSR_PAT_LEN,        64'hFFFF_FFFF_FFFF_FFE0, 8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,                   8'hAA, 1'b1, 1'b0, 32'd0},
      // single cared byte 5a, stride 4 then 2 with the region under way
      '{ROW_WRITE, CSR_PAT_LEN,        64'd1,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_CARE_MASK,      64'd1,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_LOW,    64'h5A,   8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_SCAN_STRIDE,    64'd4,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_SCAN_STRIDE,    64'd2,    8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,    8'h5A, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,    8'h5A, 1'b1, 1'b0, 32'd0},
      // stride written as zero with junk above the field, acts as one
      '{ROW_WRITE, CSR_SCAN_STRIDE,    64'hFFFF_FFFF_FFFF_FF00, 8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,                   8'hFF, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,                   8'h5A, 1'b1, 1'b0, 32'd0},
      // widest pattern bytes at the all-zero extreme
      '{ROW_WRITE, CSR_PATTERN_HIGH,   64'h0,                   8'h00, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'h0,                   8'h00, 1'b1, 1'b0, 32'd0}
   };

   logic clock = 1'b0;
   logic reset;

   mbps_req_if req_chan ();
   mbps_rsp_if rsp_chan ();
   mbps_csr_if csr_chan ();

   masked_byte_pattern_scanner_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // predictor copy of the register file, at reset values
   logic [PATTERN_W-1:0] cfg_pattern_low  = '0;
   logic [PATTERN_W-1:0] cfg_pattern_high = '0;
   logic [CARE_W-1:0]    cfg_care_mask    = '0;
   logic [LEN_W-1:0]     cfg_length       = LEN_W'(1);
   logic [STRIDE_W-1:0]  cfg_stride       = STRIDE_W'(1);

   // predictor copy of the scan state; the window is kept across regions
   logic [7:0]              scan_window [MAX_PATTERN];
   logic [OFFSET_WIDTH-1:0] scan_count     = '0;
   int                      scan_phase     = 0;
   bit                      region_matched = 1'b0;

   result_type expected_scan_results [$];
   int         mismatch_count = 0;
   int         scanned_bytes  = 0;     // bytes accepted by the block so far
   int         burst_left     = 0;

   initial begin
      foreach (scan_window[k]) scan_window[k] = 8'h00;
   end

   function automatic int effective_length();
      if (cfg_length == 0) return 1;
      if (cfg_length > MAX_PATTERN) return MAX_PATTERN;
      return int'(cfg_length);
   endfunction

   function automatic int effective_stride();
      return (cfg_stride == 0) ? 1 : int'(cfg_stride);
   endfunction

   // advance the scan by one byte; returns 1 when the byte produces a result
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output result_type res);
      int                     len;
      logic [2*PATTERN_W-1:0] pattern;
      bit                     hit;
      bit                     emitted;
      res     = '0;
      emitted = 1'b0;
      len     = effective_length();
      pattern = {cfg_pattern_high, cfg_pattern_low};
      if (!region_matched) begin
         for (int k = MAX_PATTERN - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
         scan_window[0] = b;
         // a candidate exists once a full pattern length of bytes has arrived
         if (scan_count >= OFFSET_WIDTH'(len - 1)) begin
            hit = (scan_phase == 0);
            for (int j = 0; j < len; j++) begin
               if (cfg_care_mask[j] && scan_window[len-1-j] != pattern[8*j +: 8]) hit = 1'b0;
            end
            if (hit) begin
               res.found        = 1'b1;
               res.match_offset = MATCH_OFF_W'(scan_count - OFFSET_WIDTH'(len - 1));
               emitted          = 1'b1;
               region_matched   = 1'b1;
            end
            // the wrap compares against whatever stride is current now
            scan_phase++;
            if (scan_phase >= effective_stride()) scan_phase = 0;
         end
         if (scan_count != '1) scan_count++;
      end
      if (last) begin
         if (!emitted && !region_matched) emitted = 1'b1;
         scan_count     = '0;
         scan_phase     = 0;
         region_matched = 1'b0;
      end
      return emitted;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // send one byte; the sender runs in bursts with random gaps between them
   task automatic push_byte(input logic [7:0] b, input logic last,
                            input bit typed, input result_type typed_res);
      result_type res;
      bit         produced;
      int         gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      // transaction accepted at this edge
      produced = scan_byte(b, last, res);
      if (typed) begin
         produced = 1'b1;
         res      = typed_res;
      end
      if (produced) expected_scan_results.push_back(res);
      scanned_bytes++;
      burst_left--;
   endtask

   // drop the byte stream and wait until every result has drained
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (expected_scan_results.size() != 0) @(posedge clock);
      repeat (IDLE_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_PATTERN_LOW:  cfg_pattern_low  = value;
         CSR_PATTERN_HIGH: cfg_pattern_high = value;
         CSR_CARE_MASK:    cfg_care_mask    = value[CARE_W-1:0];
         CSR_PAT_LEN:      cfg_length       = value[LEN_W-1:0];
         CSR_SCAN_STRIDE:  cfg_stride       = value[STRIDE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // result receiver: alternating runs of ready and stall, now and then a long
   // stretch of always ready
   initial begin : receiver
      int  run;
      bit  level;
      rsp_chan.ready = 1'b0;
      forever begin
         case ($urandom_range(0, 9))
            0:       begin level = 1'b1; run = $urandom_range(80, 200); end
            1, 2, 3: begin level = 1'b0; run = $urandom_range(1, 8);    end
            default: begin level = 1'b1; run = $urandom_range(1, 30);   end
         endcase
         repeat (run) begin
            @(negedge clock);
            rsp_chan.ready <= level;
         end
      end
   end

   // result checker: each transaction against the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_scan_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result found=%b offset=%0d",
                                      rsp_chan.found, rsp_chan.match_offset));
         end else begin
            want = expected_scan_results.pop_front();
            if (rsp_chan.found !== want.found)
               report_mismatch($sformatf("found got %b expected %b",
                                         rsp_chan.found, want.found));
            if (rsp_chan.match_offset !== want.match_offset)
               report_mismatch($sformatf("match_offset got %0d expected %0d",
                                         rsp_chan.match_offset, want.match_offset));
         end
      end
   end

   // hang guard
   initial begin
      #(RUN_LIMIT);
      $display("tb_masked_byte_pattern_scanner_top failed");
      $finish;
   end

   initial begin : stimulus
      scan_row_type           row;
      logic [7:0]             region_bytes [REGION_MAX];
      logic [2*PATTERN_W-1:0] pattern;
      logic [CSR_DATA_W-1:0]  junk;
      logic [CSR_DATA_W-1:0]  value;
      int                     region_len;
      int                     eff_len;
      int                     eff_stride;
      int                     pos;
      int                     shape;
      int                     pick;
      int                     j;

      // every input known from time zero
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.last_byte = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_PATTERN_LOW;
      csr_chan.data      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            settle();
            write_reg(row.reg_index, row.value);
         end else begin
            push_byte(row.data_byte, row.last_byte, row.kind == ROW_BYTE_TYPED,
                      {row.found, row.match_offset});
         end
      end

      // random phases: a fresh setting of every register, then a few regions
      while (scanned_bytes < RANDOM_ITEMS) begin
         settle();

         for (int r = 0; r < 2; r++) begin
            case ($urandom_range(0, 7))
               0:       value = '0;
               1:       value = '1;
               default: value = {$urandom, $urandom};
            endcase
            if (r == 0) write_reg(CSR_PATTERN_LOW, value);
            else        write_reg(CSR_PATTERN_HIGH, value);
         end

         // junk above each narrow field checks the masking
         junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
         case ($urandom_range(0, 7))
            0:       value = 64'(16'h0000);
            1:       value = 64'(16'hFFFF);
            2, 3:    value = 64'(16'($urandom & $urandom & $urandom));
            default: value = 64'(16'($urandom));
         endcase
         write_reg(CSR_CARE_MASK, (junk << CARE_W) | value);

         pick = $urandom_range(0, 9);
         if (pick < 6)      value = 64'($urandom_range(1, 6));
         else if (pick < 9) value = 64'($urandom_range(7, 16));
         else               value = ($urandom_range(0, 1) == 0) ? 64'd0
                                                                : 64'($urandom_range(17, 31));
         write_reg(CSR_PAT_LEN, (junk << LEN_W) | value);

         pick = $urandom_range(0, 19);
         if (pick < 11)       value = 64'd1;
         else if (pick < 16)  value = 64'($urandom_range(2, 5));
         else if (pick == 16) value = 64'd0;
         else if (pick == 17) value = 64'd255;
         else                 value = 64'($urandom_range(0, 255));
         write_reg(CSR_SCAN_STRIDE, (junk << STRIDE_W) | value);

         eff_len    = effective_length();
         eff_stride = effective_stride();
         pattern    = {cfg_pattern_high, cfg_pattern_low};

         repeat ($urandom_range(3, 8)) begin
            region_len = ($urandom_range(0, 6) == 0) ? $urandom_range(25, REGION_MAX)
                                                     : $urandom_range(1, 24);
            for (int k = 0; k < region_len; k++) region_bytes[k] = 8'($urandom);
            // mostly a planted pattern, some with one byte broken, rest noise
            shape = $urandom_range(0, 9);
            if (shape < 8 && region_len >= eff_len) begin
               pos = $urandom_range(0, region_len - eff_len);
               if ($urandom_range(0, 3) != 0) pos -= pos % eff_stride;
               for (int k = 0; k < eff_len; k++) begin
                  if (cfg_care_mask[k]) region_bytes[pos+k] = pattern[8*k +: 8];
               end
               if (shape >= 6) begin
                  j = $urandom_range(0, eff_len - 1);
                  region_bytes[pos+j] ^= 8'($urandom_range(1, 255));
               end
            end
            for (int k = 0; k < region_len; k++) begin
               push_byte(region_bytes[k], k == region_len - 1, 1'b0, '0);
            end
         end
      end

      // drain and close
      settle();
      if (mismatch_count == 0 && expected_scan_results.size() == 0) begin
         $display("tb_masked_byte_pattern_scanner_top passed");
      end else begin
         $display("tb_masked_byte_pattern_scanner_top failed");
      end
      $finish;
   end

endmodule
